// ===== rtl/stereo_point_triangulation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Stereo point triangulation unit assertion macros
// Shared concurrent assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef STEREO_POINT_TRIANGULATION_UNIT_DEFINES_SVH
`define STEREO_POINT_TRIANGULATION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/sptu_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo point triangulation package
// Shared types and constants of the triangulation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package sptu_pkg;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 8;

    localparam logic [2:0] CFG_PRINCIPAL_U   = 3'd0;
    localparam logic [2:0] CFG_PRINCIPAL_V   = 3'd1;
    localparam logic [2:0] CFG_FOCAL_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_BASELINE_UM   = 3'd3;
    localparam logic [2:0] CFG_ROW_TOLERANCE = 3'd4;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [15:0] rem;
        logic [31:0] acc;
    } t_lane;

    typedef struct packed {
        logic        ok;
        logic        mis;
        logic        bad;
        logic [15:0] dis;
        t_lane       lx;
        t_lane       ly;
        t_lane       lz;
    } t_div;
endpackage
`default_nettype wire

// ===== rtl/stereo_point_triangulation_unit.sv =====
// Requests pass through stages A, B and C, the divider stages and the output
// register. Throughput: one request per cycle while the master side does not
// stall; eight divider stages of four quotient bits each set the pipeline depth.
// Stages advance independently, so bubbles are filled while the output stalls.
// Reset (synchronous, active low) empties the pipeline and loads the
// configuration defaults.
// ----------------------------------------------------------------------------
// Stereo point triangulation unit
// Checks a matched stereo pair and triangulates it into a 3-D point.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_point_triangulation_unit_defines.svh"
module stereo_point_triangulation_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // left_x, left_y, right_x, right_y
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // point_x, point_y, point_z, zero pad
    output logic [95:0]      m_axis_tdata,
    // accepted, row_mismatch, bad_disparity
    output logic [2:0]       m_axis_tuser
);
    localparam int NS = sptu_pkg::DIV_STAGES;

    logic [15:0] r_uc, r_vc, r_f, r_tol;
    logic [19:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uc  <= 16'd0;
            r_vc  <= 16'd0;
            r_f   <= 16'd1;
            r_b   <= 20'd1;
            r_tol <= 16'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sptu_pkg::CFG_PRINCIPAL_U:   r_uc  <= i_cfg_data[15:0];
                sptu_pkg::CFG_PRINCIPAL_V:   r_vc  <= i_cfg_data[15:0];
                sptu_pkg::CFG_FOCAL_LENGTH:  r_f   <= i_cfg_data[15:0];
                sptu_pkg::CFG_BASELINE_UM:   r_b   <= i_cfg_data;
                sptu_pkg::CFG_ROW_TOLERANCE: r_tol <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic adv_a, adv_b, adv_c, adv_o;
    logic w_adv [NS];
    logic w_v [NS+1];
    sptu_pkg::t_div w_d [NS+1];

    // stage A: checks and offsets
    logic [15:0] lx, ly, rx, ry;
    logic [16:0] dy, ady, dd, sx, sy;
    assign lx  = s_axis_tdata[15:0];
    assign ly  = s_axis_tdata[31:16];
    assign rx  = s_axis_tdata[47:32];
    assign ry  = s_axis_tdata[63:48];
    assign dy  = {1'b0, ly} - {1'b0, ry};
    assign ady = dy[16] ? (17'd0 - dy) : dy;
    assign dd  = {1'b0, lx} - {1'b0, rx};
    assign sx  = {1'b0, rx} - {1'b0, r_uc};
    assign sy  = {1'b0, ry} - {1'b0, r_vc};

    logic        r_a_valid, r_a_mis, r_a_bad, r_a_negx, r_a_negy;
    logic [15:0] r_a_dis, r_a_magx, r_a_magy, r_a_f;
    logic [19:0] r_a_b;
    logic [16:0] n_magx, n_magy;
    assign n_magx = sx[16] ? (17'd0 - sx) : sx;
    assign n_magy = sy[16] ? (17'd0 - sy) : sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else if (adv_a) r_a_valid <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_mis  <= ady >= {1'b0, r_tol};
            r_a_bad  <= dd[16] || (dd == 17'd0);
            r_a_dis  <= dd[15:0];
            r_a_negx <= sx[16];
            r_a_negy <= sy[16];
            r_a_magx <= n_magx[15:0];
            r_a_magy <= n_magy[15:0];
            r_a_f    <= r_f;
            r_a_b    <= r_b;
        end
    end

    // stage B: products
    logic        r_b_valid, r_b_mis, r_b_bad, r_b_negx, r_b_negy;
    logic [15:0] r_b_dis;
    logic [35:0] r_b_px, r_b_py, r_b_pz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_valid <= 1'b0;
        else if (adv_b) r_b_valid <= r_a_valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b_mis  <= r_a_mis;
            r_b_bad  <= r_a_bad;
            r_b_dis  <= r_a_dis;
            r_b_negx <= r_a_negx;
            r_b_negy <= r_a_negy;
            r_b_px   <= r_a_b * r_a_magx;
            r_b_py   <= r_a_b * r_a_magy;
            r_b_pz   <= r_a_b * r_a_f;
        end
    end

    // stage C: overflow check and divider set-up
    function automatic sptu_pkg::t_lane lane_init(logic neg, logic [35:0] p, logic [15:0] d);
        sptu_pkg::t_lane l;
        l.neg = neg;
        l.ovf = {12'd0, p[35:32]} >= d;
        l.rem = l.ovf ? 16'd0 : {12'd0, p[35:32]};
        l.acc = p[31:0];
        return l;
    endfunction

    logic           r_c_valid;
    sptu_pkg::t_div r_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_valid <= 1'b0;
        else if (adv_c) r_c_valid <= r_b_valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_c.ok  <= !r_b_mis && !r_b_bad;
            r_c.mis <= r_b_mis;
            r_c.bad <= r_b_bad;
            r_c.dis <= r_b_dis;
            r_c.lx  <= lane_init(r_b_negx, r_b_px, r_b_dis);
            r_c.ly  <= lane_init(r_b_negy, r_b_py, r_b_dis);
            r_c.lz  <= lane_init(1'b0, r_b_pz, r_b_dis);
        end
    end

    assign w_v[0] = r_c_valid;
    assign w_d[0] = r_c;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_div
            if (k == NS - 1) begin : g_last
                assign w_adv[k] = !w_v[k+1] || adv_o;
            end else begin : g_mid
                assign w_adv[k] = !w_v[k+1] || w_adv[k+1];
            end
            sptu_div_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv[k]),
                .i_valid (w_v[k]),
                .i_item  (w_d[k]),
                .o_valid (w_v[k+1]),
                .o_item  (w_d[k+1])
            );
        end
    endgenerate

    assign adv_c = !r_c_valid || w_adv[0];
    assign adv_b = !r_b_valid || adv_c;
    assign adv_a = !r_a_valid || adv_b;
    assign adv_o = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv_a;

    // output stage: saturate and zero rejected pairs
    function automatic logic [31:0] sat_s32(sptu_pkg::t_lane l);
        logic big;
        big = l.ovf || l.acc[31];
        if (l.neg) return big ? 32'h8000_0000 : (32'd0 - l.acc);
        return big ? 32'h7FFF_FFFF : l.acc;
    endfunction

    sptu_pkg::t_div fin;
    logic [31:0] n_px, n_py;
    logic [30:0] n_pz;
    assign fin  = w_d[NS];
    assign n_px = fin.ok ? sat_s32(fin.lx) : 32'd0;
    assign n_py = fin.ok ? sat_s32(fin.ly) : 32'd0;
    assign n_pz = !fin.ok ? 31'd0 :
                  (fin.lz.ovf || fin.lz.acc[31]) ? 31'h7FFF_FFFF : fin.lz.acc[30:0];

    logic        r_o_valid;
    logic [95:0] r_o_data;
    logic [2:0]  r_o_user;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (adv_o) r_o_valid <= w_v[NS];
    end
    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_o_data <= {1'b0, n_pz, n_py, n_px};
            r_o_user <= {fin.bad, fin.mis, fin.ok};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

    `ASSERT_IMPLY(a_ok_flags, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[0] == !(m_axis_tuser[1] || m_axis_tuser[2]))
    `ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 96'd0)
    `ASSERT_NEXT(a_enter, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_a_valid)
endmodule
`default_nettype wire

// ===== rtl/sptu_div_stage.sv =====
// ----------------------------------------------------------------------------
// Triangulation divider stage
// Four restoring division steps on all three lanes, then a register.
// ----------------------------------------------------------------------------
`default_nettype none
module sptu_div_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire sptu_pkg::t_div i_item,
    output logic               o_valid,
    output sptu_pkg::t_div     o_item
);
    logic           r_valid;
    sptu_pkg::t_div r_item;
    sptu_pkg::t_div n_item;

    function automatic sptu_pkg::t_lane div_step(sptu_pkg::t_lane l, logic [15:0] d);
        logic [16:0] t;
        logic [16:0] diff;
        sptu_pkg::t_lane r;
        t    = {l.rem, l.acc[31]};
        diff = t - {1'b0, d};
        r    = l;
        if (t >= {1'b0, d}) begin
            r.rem = diff[15:0];
            r.acc = {l.acc[30:0], 1'b1};
        end else begin
            r.rem = t[15:0];
            r.acc = {l.acc[30:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_item = i_item;
        for (int s = 0; s < sptu_pkg::DIV_STEPS; s++) begin
            n_item.lx = div_step(n_item.lx, n_item.dis);
            n_item.ly = div_step(n_item.ly, n_item.dis);
            n_item.lz = div_step(n_item.lz, n_item.dis);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule
`default_nettype wire
